/* rtl/core/bcld_pkg.sv */
// Shared types and constants for the button click / long press detector.
// Holds the phase encoding, event bit positions, register indexes and the
// configuration bundle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcld_pkg;

    // widths of the item fields and registers
    localparam int TimeWidth  = 32;
    localparam int MsWidth    = 16;
    localparam int EventWidth = 6;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 16;

    // event bit positions
    localparam int EvPressStart = 0;
    localparam int EvClick      = 1;
    localparam int EvDouble     = 2;
    localparam int EvLongStart  = 3;
    localparam int EvLongDuring = 4;
    localparam int EvLongStop   = 5;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE     = 3'd0,
        CFG_CLICK_WINDOW = 3'd1,
        CFG_LONG_PRESS   = 3'd2,
        CFG_ACTIVE_LOW   = 3'd3,
        CFG_EVENT_ENABLE = 3'd4
    } cfg_idx_t;

    // reset values of the registers
    localparam logic [MsWidth-1:0]    DebounceReset    = 16'd50;
    localparam logic [MsWidth-1:0]    ClickWindowReset = 16'd600;
    localparam logic [MsWidth-1:0]    LongPressReset   = 16'd1000;
    localparam logic                  ActiveLowReset   = 1'b1;
    localparam logic [EventWidth-1:0] EventEnableReset = 6'h3f;

    // one-hot press phases
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_HELD     = 5'b00010,
        PH_RELEASED = 5'b00100,
        PH_SECOND   = 5'b01000,
        PH_LONG     = 5'b10000
    } phase_t;

    // configuration bundle seen by the classifier
    typedef struct packed {
        logic [MsWidth-1:0]    debounce_ms;
        logic [MsWidth-1:0]    click_window_ms;
        logic [MsWidth-1:0]    long_press_ms;
        logic                  active_low;
        logic [EventWidth-1:0] event_enable;
    } cfg_t;

    // one classified result
    typedef struct packed {
        logic [EventWidth-1:0] events;
        logic                  long_pressed;
        logic [TimeWidth-1:0]  pressed_ms;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/bcld_cfg_regs.sv */
// Configuration register file of the button detector.
// Plain write port, no read-back; depends on bcld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcld_cfg_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [bcld_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [bcld_pkg::CfgDataW-1:0] cfg_data,
    output bcld_pkg::cfg_t                     cfg
);

    bcld_pkg::cfg_t cfg_reg;
    bcld_pkg::cfg_t cfg_next;

    // register decode, unknown indexes leave everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                bcld_pkg::CFG_DEBOUNCE:     cfg_next.debounce_ms     = cfg_data;
                bcld_pkg::CFG_CLICK_WINDOW: cfg_next.click_window_ms = cfg_data;
                bcld_pkg::CFG_LONG_PRESS:   cfg_next.long_press_ms   = cfg_data;
                bcld_pkg::CFG_ACTIVE_LOW:   cfg_next.active_low      = cfg_data[0];
                bcld_pkg::CFG_EVENT_ENABLE:
                    cfg_next.event_enable = cfg_data[bcld_pkg::EventWidth-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= bcld_pkg::DebounceReset;
            cfg_reg.click_window_ms <= bcld_pkg::ClickWindowReset;
            cfg_reg.long_press_ms   <= bcld_pkg::LongPressReset;
            cfg_reg.active_low      <= bcld_pkg::ActiveLowReset;
            cfg_reg.event_enable    <= bcld_pkg::EventEnableReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/bcld_classifier.sv */
// Press classifier: phase machine, press/release timestamps and long flag.
// Classifies one sample per step; depends on bcld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcld_classifier
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [bcld_pkg::TimeWidth-1:0] now_ms,
    input  wire logic                           pin_level,
    input  wire bcld_pkg::cfg_t                 cfg,
    output bcld_pkg::result_t                   result
);

    bcld_pkg::phase_t                 phase_reg, phase_next;
    logic [bcld_pkg::TimeWidth-1:0]   press_time_reg, press_time_next;
    logic [bcld_pkg::TimeWidth-1:0]   release_time_reg, release_time_next;
    logic                             long_flag_reg, long_flag_next;
    logic [bcld_pkg::EventWidth-1:0]  ev;
    logic                             active;
    logic [bcld_pkg::TimeWidth-1:0]   since_press;
    logic [bcld_pkg::TimeWidth-1:0]   since_release;
    logic [bcld_pkg::TimeWidth-1:0]   debounce_w;
    logic [bcld_pkg::TimeWidth-1:0]   window_w;
    logic [bcld_pkg::TimeWidth-1:0]   long_w;

    // elapsed times, modulo 2^32
    assign active        = (pin_level != cfg.active_low);
    assign since_press   = now_ms - press_time_reg;
    assign since_release = now_ms - release_time_reg;
    assign debounce_w    = {{(bcld_pkg::TimeWidth-bcld_pkg::MsWidth){1'b0}}, cfg.debounce_ms};
    assign window_w      = {{(bcld_pkg::TimeWidth-bcld_pkg::MsWidth){1'b0}},
                            cfg.click_window_ms};
    assign long_w        = {{(bcld_pkg::TimeWidth-bcld_pkg::MsWidth){1'b0}}, cfg.long_press_ms};

    // phase machine
    always_comb
    begin
        phase_next        = phase_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        long_flag_next    = long_flag_reg;
        ev                = '0;
        case (phase_reg)
            bcld_pkg::PH_HELD:
            begin
                if (!active && since_press < debounce_w)
                begin
                    phase_next = bcld_pkg::PH_IDLE;
                end
                else if (!active)
                begin
                    phase_next        = bcld_pkg::PH_RELEASED;
                    release_time_next = now_ms;
                end
                else if (since_press > long_w)
                begin
                    long_flag_next                  = 1'b1;
                    ev[bcld_pkg::EvLongStart]       = 1'b1;
                    ev[bcld_pkg::EvLongDuring]      = 1'b1;
                    phase_next                      = bcld_pkg::PH_LONG;
                    release_time_next               = now_ms;
                end
                else
                begin
                    ev[bcld_pkg::EvPressStart] = 1'b1;
                end
            end
            bcld_pkg::PH_RELEASED:
            begin
                if (!cfg.event_enable[bcld_pkg::EvDouble] || since_press > window_w)
                begin
                    ev[bcld_pkg::EvClick] = 1'b1;
                    phase_next            = bcld_pkg::PH_IDLE;
                end
                else if (active && since_release > debounce_w)
                begin
                    phase_next      = bcld_pkg::PH_SECOND;
                    press_time_next = now_ms;
                end
            end
            bcld_pkg::PH_SECOND:
            begin
                if (!active && since_press > debounce_w)
                begin
                    ev[bcld_pkg::EvDouble] = 1'b1;
                    phase_next             = bcld_pkg::PH_IDLE;
                    release_time_next      = now_ms;
                end
            end
            bcld_pkg::PH_LONG:
            begin
                if (!active)
                begin
                    long_flag_next           = 1'b0;
                    ev[bcld_pkg::EvLongStop] = 1'b1;
                    phase_next               = bcld_pkg::PH_IDLE;
                    release_time_next        = now_ms;
                end
                else
                begin
                    long_flag_next             = 1'b1;
                    ev[bcld_pkg::EvLongDuring] = 1'b1;
                end
            end
            default:
            begin
                // idle, and any stray code behaves as idle
                phase_next = bcld_pkg::PH_IDLE;
                if (active)
                begin
                    phase_next      = bcld_pkg::PH_HELD;
                    press_time_next = now_ms;
                end
            end
        endcase
    end

    // result for this sample, seen after the update
    assign result.events       = ev & cfg.event_enable;
    assign result.long_pressed = long_flag_next;
    assign result.pressed_ms   = release_time_next - press_time_next;

    // state registers advance once per classified sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= bcld_pkg::PH_IDLE;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            long_flag_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            long_flag_reg    <= long_flag_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/button_click_long_press_detector_core.sv */
// Button click / double click / long press detector, top level.
// Uses bcld_pkg, bcld_cfg_regs and bcld_classifier.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one sample tick per item:
//   a millisecond timestamp now_ms and the raw pin_level. Output channel
//   (out_valid / out_stall) returns exactly one result item per sample:
//   the enabled events, the long press flag and the last press duration.
//   Path: a sample accepted at a clock edge lands in the input
//   register, is classified and written to the output register when
//   it advances, and its result then shows on the ports.
//   Throughput: one item per clock while out_stall does not hold a result;
//   the phase update is combinational between the input and output registers.
//   Stall: when out_stall holds a result, the input register keeps its
//   sample and in_stall rises while it is full; no item is lost.
//   Reset: clears both pipeline valids, sets the phase machine to idle
//   with zero timestamps, and loads register defaults 50, 600, 1000,
//   active low, all events enabled. Register writes are for the user to
//   make only when the block is idle, which the block itself does not enforce; they apply to the next sample.
`timescale 1ns / 1ps
`default_nettype none

module button_click_long_press_detector_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_write_en,
    input  wire logic [bcld_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [bcld_pkg::CfgDataW-1:0]   cfg_data,
    // sample items
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [bcld_pkg::TimeWidth-1:0]  now_ms,
    input  wire logic                            pin_level,
    // result items
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [bcld_pkg::EventWidth-1:0]      events,
    output logic                                 long_pressed,
    output logic [bcld_pkg::TimeWidth-1:0]       pressed_ms
);

    bcld_pkg::cfg_t                  cfg;
    bcld_pkg::result_t               result;
    logic                            s1_valid_reg;
    logic [bcld_pkg::TimeWidth-1:0]  s1_now_reg;
    logic                            s1_pin_reg;
    logic                            out_valid_reg;
    bcld_pkg::result_t               out_reg;
    logic                            advance;
    logic                            in_accept;

    bcld_cfg_regs u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // handshake control
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    bcld_classifier u_cls
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .now_ms    (s1_now_reg),
        .pin_level (s1_pin_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_now_reg <= now_ms;
            s1_pin_reg <= pin_level;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign events       = out_reg.events;
    assign long_pressed = out_reg.long_pressed;
    assign pressed_ms   = out_reg.pressed_ms;

endmodule

`default_nettype wire
